// ----- sv/usg_pkg.sv -----
// shared types and constants for the utf8 / ansi character segmenter
package usg_pkg;

  localparam int unsigned MaxEscBytes = 8;
  localparam int unsigned MaxBytes    = 8;

  localparam logic [7:0] EscByte   = 8'h1b;
  localparam logic [7:0] LowerA    = 8'h61;
  localparam logic [7:0] LowerZ    = 8'h7a;
  localparam logic [23:0] KanaLow  = 24'hefbdb1;
  localparam logic [23:0] KanaHigh = 24'hefbe9f;

  localparam logic [1:0] WidthEsc    = 2'd0;
  localparam logic [1:0] WidthNarrow = 2'd1;
  localparam logic [1:0] WidthWide   = 2'd2;

  typedef struct packed {
    logic [63:0] accum;
    logic [3:0]  taken;
    logic [2:0]  expected;
    logic        in_esc;
    logic        mid_char;
  } usg_state_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] value;
    logic [3:0]  size;
    logic [1:0]  width;
  } usg_result_t;

  // utf8 length from the lead byte, invalid leads count as one
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

endpackage

// ----- sv/usg_step.sv -----
// next-state and result logic for one input byte
module usg_step (
  input  usg_pkg::usg_state_t  state_i,
  input  logic [7:0]           byte_i,
  input  logic                 raw_mode_i,
  output usg_pkg::usg_state_t  state_o,
  output usg_pkg::usg_result_t res_o
);
  import usg_pkg::*;

  logic [63:0] accum_ins;
  logic [3:0]  taken_inc;
  logic [2:0]  lead_len;
  logic [23:0] be_word;
  logic        is_lower;
  logic        done;

  always_comb begin
    accum_ins = state_i.accum;
    taken_inc = state_i.taken;
    if (state_i.taken < 4'(MaxBytes)) begin
      for (int i = 0; i < 8; i++) begin
        if (state_i.taken[2:0] == 3'(i)) begin
          accum_ins[8*i +: 8] = byte_i;
        end
      end
      taken_inc = state_i.taken + 4'd1;
    end
  end

  assign lead_len = lead_length(byte_i);
  assign be_word  = {accum_ins[7:0], accum_ins[15:8], accum_ins[23:16]};
  assign is_lower = byte_i inside {[LowerA:LowerZ]};

  always_comb begin
    state_o     = state_i;
    res_o.valid = 1'b0;
    res_o.value = accum_ins;
    res_o.size  = taken_inc;
    res_o.width = WidthWide;
    done        = 1'b0;

    if (!state_i.mid_char) begin
      res_o.value = {56'd0, byte_i};
      res_o.size  = 4'd1;
      res_o.width = WidthNarrow;
      if (byte_i != 8'd0) begin
        state_o.accum    = {56'd0, byte_i};
        state_o.taken    = 4'd1;
        state_o.expected = 3'd0;
        if (!raw_mode_i && byte_i == EscByte) begin
          state_o.in_esc   = 1'b1;
          state_o.mid_char = 1'b1;
        end else if (lead_len == 3'd1) begin
          res_o.valid = 1'b1;
          state_o     = '0;
        end else begin
          state_o.expected = lead_len;
          state_o.in_esc   = 1'b0;
          state_o.mid_char = 1'b1;
        end
      end
    end else begin
      state_o.accum = accum_ins;
      state_o.taken = taken_inc;
      if (state_i.in_esc) begin
        // escape ends on a lowercase letter or at the length cap
        done        = is_lower || (taken_inc >= 4'(MaxEscBytes));
        res_o.width = WidthEsc;
      end else begin
        done = taken_inc >= {1'b0, state_i.expected};
        if (taken_inc == 4'd3 && be_word >= KanaLow && be_word <= KanaHigh) begin
          res_o.width = WidthNarrow;
        end else begin
          res_o.width = WidthWide;
        end
      end
      if (done) begin
        res_o.valid = 1'b1;
        state_o     = '0;
      end
    end
  end

endmodule

// ----- sv/utf8_ansi_char_segmenter_core.sv -----
// top level of the utf8 / ansi character segmenter
//
// takes one byte per request on the input channel and groups bytes into
// display characters; each finished character leaves as one request on the
// output channel with its packed bytes, byte count and display width
// an escape sequence (esc while raw mode is off) runs to a lowercase letter
// or eight bytes and has width 0; a nul byte at a character start is dropped
// a byte is accepted in every cycle that input is not stalled; the byte that
// completes a character shows on the output in the cycle after it is accepted
// the per-byte work is a single pass of compare and byte-insert logic
// between the state registers and the output register
// while the receiver stalls a full output register, input is stalled too;
// if the output register is empty or being taken, input flows freely
// reset clears raw mode, the pending character and the output valid
// raw mode is to be written through cfg_we_i / cfg_wdata_i by the user only
// while the block is idle, unchecked here; it is sampled at each lead byte
module utf8_ansi_char_segmenter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] char_value_o,
  output logic [3:0]  char_size_o,
  output logic [1:0]  char_width_o
);
  import usg_pkg::*;

  logic        raw_mode_q;
  usg_state_t  state_q, state_d;
  usg_result_t res;
  logic        in_accept;
  logic        out_valid_q, out_valid_d;
  logic [63:0] value_q;
  logic [3:0]  size_q;
  logic [1:0]  width_q;

  usg_step u_step (
    .state_i    (state_q),
    .byte_i     (in_byte_i),
    .raw_mode_i (raw_mode_q),
    .state_o    (state_d),
    .res_o      (res)
  );

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (in_accept && res.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        raw_mode_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && res.valid) begin
      value_q <= res.value;
      size_q  <= res.size;
      width_q <= res.width;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_value_o = value_q;
  assign char_size_o  = size_q;
  assign char_width_o = width_q;

endmodule
